// ----- design/fecb_pkg.sv -----
// shared types and constants for the field element canonical byte encoder
package fecb_pkg;

  localparam int unsigned LIMB_W  = 51;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CARRY_W = WORD_W - LIMB_W;
  localparam int unsigned CFG_W   = 2;
  localparam int unsigned PACK_W  = 256;
  localparam int unsigned L2_KEEP = 58;

  typedef logic [LIMB_W-1:0]  limb_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [CARRY_W-1:0] carry_t;

  typedef enum logic [CFG_W-1:0] {
    CFG_GAMMA0 = 2'd0,
    CFG_GAMMA1 = 2'd1,
    CFG_GAMMA2 = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    limb_t g0;
    limb_t g1;
    limb_t g2;
  } gamma_t;

  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

  typedef struct packed {
    limb_t  t0;
    limb_t  t1;
    limb_t  t2;
    limb_t  t3;
    limb_t  t4;
    carry_t c;
  } carried_t;

  typedef struct packed {
    limb_t t0;
    limb_t t1;
    word_t t2;
    limb_t t3;
    limb_t t4;
  } folded_t;

endpackage

// ----- design/fecb_if.sv -----
// valid/ready channel interfaces for limb input and byte word output
interface fecb_in_if
  import fecb_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t limb0;
  word_t limb1;
  word_t limb2;
  word_t limb3;
  word_t limb4;

  modport source (output valid, limb0, limb1, limb2, limb3, limb4, input ready);
  modport sink   (input valid, limb0, limb1, limb2, limb3, limb4, output ready);
endinterface

interface fecb_out_if
  import fecb_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t bytes_word0;
  word_t bytes_word1;
  word_t bytes_word2;
  word_t bytes_word3;

  modport source (output valid, bytes_word0, bytes_word1, bytes_word2, bytes_word3,
                  input ready);
  modport sink   (input valid, bytes_word0, bytes_word1, bytes_word2, bytes_word3,
                  output ready);
endinterface

// ----- design/fecb_carry.sv -----
// four stage carry chain over the five input limbs
module fecb_carry
  import fecb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pipe_ctl_t ctl_i,
  input  word_t     limb0_i,
  input  word_t     limb1_i,
  input  word_t     limb2_i,
  input  word_t     limb3_i,
  input  word_t     limb4_i,
  output logic      vld_o,
  output carried_t  data_o
);

  logic  v1_q, v2_q, v3_q, v4_q;
  limb_t s1_t0_q;
  word_t s1_t1_q, s1_t2_q, s1_t3_q, s1_t4_q;
  limb_t s2_t0_q, s2_t1_q;
  word_t s2_t2_q, s2_t3_q, s2_t4_q;
  limb_t s3_t0_q, s3_t1_q, s3_t2_q;
  word_t s3_t3_q, s3_t4_q;
  carried_t s4_q;

  word_t s1_t1_d, s2_t2_d, s3_t3_d, s4_sum_d;

  assign s1_t1_d  = limb1_i + WORD_W'(limb0_i[WORD_W-1:LIMB_W]);
  assign s2_t2_d  = s1_t2_q + WORD_W'(s1_t1_q[WORD_W-1:LIMB_W]);
  assign s3_t3_d  = s2_t3_q + WORD_W'(s2_t2_q[WORD_W-1:LIMB_W]);
  assign s4_sum_d = s3_t4_q + WORD_W'(s3_t3_q[WORD_W-1:LIMB_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (ctl_i.adv) begin
      v1_q <= ctl_i.vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      s1_t0_q <= limb0_i[LIMB_W-1:0];
      s1_t1_q <= s1_t1_d;
      s1_t2_q <= limb2_i;
      s1_t3_q <= limb3_i;
      s1_t4_q <= limb4_i;

      s2_t0_q <= s1_t0_q;
      s2_t1_q <= s1_t1_q[LIMB_W-1:0];
      s2_t2_q <= s2_t2_d;
      s2_t3_q <= s1_t3_q;
      s2_t4_q <= s1_t4_q;

      s3_t0_q <= s2_t0_q;
      s3_t1_q <= s2_t1_q;
      s3_t2_q <= s2_t2_q[LIMB_W-1:0];
      s3_t3_q <= s3_t3_d;
      s3_t4_q <= s2_t4_q;

      s4_q.t0 <= s3_t0_q;
      s4_q.t1 <= s3_t1_q;
      s4_q.t2 <= s3_t2_q;
      s4_q.t3 <= s3_t3_q[LIMB_W-1:0];
      s4_q.t4 <= s4_sum_d[LIMB_W-1:0];
      s4_q.c  <= s4_sum_d[WORD_W-1:LIMB_W];
    end
  end

  assign vld_o  = v4_q;
  assign data_o = s4_q;

endmodule

// ----- design/fecb_fold.sv -----
// fold of the top carry times gamma and the short re-carry, four stages
module fecb_fold
  import fecb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pipe_ctl_t ctl_i,
  input  gamma_t    gamma_i,
  input  carried_t  data_i,
  output logic      vld_o,
  output folded_t   data_o
);

  logic  v5_q, v6_q, v7_q, v8_q;
  word_t s5_p0_q, s5_p1_q, s5_p2_q;
  limb_t s5_t0_q, s5_t1_q, s5_t2_q, s5_t3_q, s5_t4_q;
  word_t s6_a0_q, s6_a1_q, s6_a2_q;
  limb_t s6_t3_q, s6_t4_q;
  limb_t s7_t0_q;
  word_t s7_t1_q, s7_t2_q;
  limb_t s7_t3_q, s7_t4_q;
  folded_t s8_q;

  word_t s5_p0_d, s5_p1_d, s5_p2_d;
  word_t s7_t1_d, s8_t2_d;

  assign s5_p0_d = WORD_W'(data_i.c) * WORD_W'(gamma_i.g0);
  assign s5_p1_d = WORD_W'(data_i.c) * WORD_W'(gamma_i.g1);
  assign s5_p2_d = WORD_W'(data_i.c) * WORD_W'(gamma_i.g2);
  assign s7_t1_d = s6_a1_q + WORD_W'(s6_a0_q[WORD_W-1:LIMB_W]);
  assign s8_t2_d = s7_t2_q + WORD_W'(s7_t1_q[WORD_W-1:LIMB_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (ctl_i.adv) begin
      v5_q <= ctl_i.vld;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      s5_p0_q <= s5_p0_d;
      s5_p1_q <= s5_p1_d;
      s5_p2_q <= s5_p2_d;
      s5_t0_q <= data_i.t0;
      s5_t1_q <= data_i.t1;
      s5_t2_q <= data_i.t2;
      s5_t3_q <= data_i.t3;
      s5_t4_q <= data_i.t4;

      s6_a0_q <= WORD_W'(s5_t0_q) + s5_p0_q;
      s6_a1_q <= WORD_W'(s5_t1_q) + s5_p1_q;
      s6_a2_q <= WORD_W'(s5_t2_q) + s5_p2_q;
      s6_t3_q <= s5_t3_q;
      s6_t4_q <= s5_t4_q;

      s7_t0_q <= s6_a0_q[LIMB_W-1:0];
      s7_t1_q <= s7_t1_d;
      s7_t2_q <= s6_a2_q;
      s7_t3_q <= s6_t3_q;
      s7_t4_q <= s6_t4_q;

      s8_q.t0 <= s7_t0_q;
      s8_q.t1 <= s7_t1_q[LIMB_W-1:0];
      s8_q.t2 <= s8_t2_d;
      s8_q.t3 <= s7_t3_q;
      s8_q.t4 <= s7_t4_q;
    end
  end

  assign vld_o  = v8_q;
  assign data_o = s8_q;

endmodule

// ----- design/fecb_canon.sv -----
// add gamma, pick t or t - q on the bit 255 carry, pack into byte words
module fecb_canon
  import fecb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pipe_ctl_t ctl_i,
  input  gamma_t    gamma_i,
  input  folded_t   data_i,
  output logic      vld_o,
  output word_t     word0_o,
  output word_t     word1_o,
  output word_t     word2_o,
  output word_t     word3_o
);

  logic    v9_q, v10_q, v11_q, v12_q;
  folded_t s9_t_q, s10_t_q, s11_t_q;
  limb_t   s9_u0_q, s9_u1_q;
  logic    s9_c_q;
  limb_t   s10_u0_q, s10_u1_q, s10_u2_q;
  carry_t  s10_c_q;
  limb_t   s11_u0_q, s11_u1_q, s11_u2_q, s11_u3_q, s11_u4_q;
  logic    s11_sel_q;
  logic [PACK_W-1:0] pack_q;

  logic [LIMB_W:0] u0_d, u1_d, u3_d, u4_d;
  word_t           u2_d;
  limb_t           r0, r1, r3, r4;
  word_t           r2;
  logic [PACK_W-1:0] pack_d;

  assign u0_d = {1'b0, data_i.t0} + {1'b0, gamma_i.g0};
  assign u1_d = {1'b0, data_i.t1} + {1'b0, gamma_i.g1} + (LIMB_W+1)'(u0_d[LIMB_W]);
  assign u2_d = s9_t_q.t2 + WORD_W'(gamma_i.g2) + WORD_W'(s9_c_q);
  assign u3_d = {1'b0, s10_t_q.t3} + (LIMB_W+1)'(s10_c_q);
  assign u4_d = {1'b0, s10_t_q.t4} + (LIMB_W+1)'(u3_d[LIMB_W]);

  always_comb begin
    r0 = s11_sel_q ? s11_u0_q : s11_t_q.t0;
    r1 = s11_sel_q ? s11_u1_q : s11_t_q.t1;
    r2 = s11_sel_q ? WORD_W'(s11_u2_q) : s11_t_q.t2;
    r3 = s11_sel_q ? s11_u3_q : s11_t_q.t3;
    r4 = s11_sel_q ? s11_u4_q : s11_t_q.t4;
    // high bits of an oversized limb 2 land in byte 19 and no further
    pack_d = PACK_W'(r0)
           | (PACK_W'(r1) << LIMB_W)
           | (PACK_W'(r2[L2_KEEP-1:0]) << (2*LIMB_W))
           | (PACK_W'(r3) << (3*LIMB_W))
           | (PACK_W'(r4) << (4*LIMB_W));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else if (ctl_i.adv) begin
      v9_q  <= ctl_i.vld;
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      s9_t_q   <= data_i;
      s9_u0_q  <= u0_d[LIMB_W-1:0];
      s9_u1_q  <= u1_d[LIMB_W-1:0];
      s9_c_q   <= u1_d[LIMB_W];

      s10_t_q  <= s9_t_q;
      s10_u0_q <= s9_u0_q;
      s10_u1_q <= s9_u1_q;
      s10_u2_q <= u2_d[LIMB_W-1:0];
      s10_c_q  <= u2_d[WORD_W-1:LIMB_W];

      s11_t_q   <= s10_t_q;
      s11_u0_q  <= s10_u0_q;
      s11_u1_q  <= s10_u1_q;
      s11_u2_q  <= s10_u2_q;
      s11_u3_q  <= u3_d[LIMB_W-1:0];
      s11_u4_q  <= u4_d[LIMB_W-1:0];
      s11_sel_q <= u4_d[LIMB_W];

      pack_q <= pack_d;
    end
  end

  assign vld_o   = v12_q;
  assign word0_o = pack_q[WORD_W-1:0];
  assign word1_o = pack_q[2*WORD_W-1:WORD_W];
  assign word2_o = pack_q[3*WORD_W-1:2*WORD_W];
  assign word3_o = pack_q[4*WORD_W-1:3*WORD_W];

endmodule

// ----- design/field_element_canonical_to_bytes_core.sv -----
// top level: canonical 32 byte encoding of radix 2^51 field elements
//
//   channel  role    payload
//   in_i     sink    limb0..limb4, 64 bits each
//   out_o    source  bytes_word0..bytes_word3, 64 bits each
//   cfg      write   cfg_we_i, cfg_idx_i, cfg_data_i (gamma limbs 0..2)
//
// twelve register stages, one element per cycle while the output is not stalled
// each stage of the limb carry chain holds one 64 bit add
// all stages move together; a stalled output holds every stage in place
// reset clears the stage valid bits and the gamma registers
module field_element_canonical_to_bytes_core
  import fecb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  fecb_in_if.sink           in_i,
  fecb_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_idx_i,
  input  limb_t             cfg_data_i
);

  gamma_t    gamma_q;
  pipe_ctl_t ctl_in, ctl_fold, ctl_canon;
  logic      adv;
  logic      carry_vld, fold_vld, out_vld;
  carried_t  carry_data;
  folded_t   fold_data;

  assign adv      = !out_vld || out_o.ready;
  assign in_i.ready = adv;

  assign ctl_in    = '{adv: adv, vld: in_i.valid};
  assign ctl_fold  = '{adv: adv, vld: carry_vld};
  assign ctl_canon = '{adv: adv, vld: fold_vld};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_GAMMA0: gamma_q.g0 <= cfg_data_i;
        CFG_GAMMA1: gamma_q.g1 <= cfg_data_i;
        CFG_GAMMA2: gamma_q.g2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fecb_carry u_carry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_in),
    .limb0_i (in_i.limb0),
    .limb1_i (in_i.limb1),
    .limb2_i (in_i.limb2),
    .limb3_i (in_i.limb3),
    .limb4_i (in_i.limb4),
    .vld_o   (carry_vld),
    .data_o  (carry_data)
  );

  fecb_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_fold),
    .gamma_i (gamma_q),
    .data_i  (carry_data),
    .vld_o   (fold_vld),
    .data_o  (fold_data)
  );

  fecb_canon u_canon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_canon),
    .gamma_i (gamma_q),
    .data_i  (fold_data),
    .vld_o   (out_vld),
    .word0_o (out_o.bytes_word0),
    .word1_o (out_o.bytes_word1),
    .word2_o (out_o.bytes_word2),
    .word3_o (out_o.bytes_word3)
  );

  assign out_o.valid = out_vld;

endmodule
